// ===== src/rair_pkg.sv =====
package rair_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_PLANE_AXIS      = 3'd0;
	localparam logic [2:0] REG_PLANE_POS       = 3'd1;
	localparam logic [2:0] REG_LO_A            = 3'd2;
	localparam logic [2:0] REG_HI_A            = 3'd3;
	localparam logic [2:0] REG_LO_B            = 3'd4;
	localparam logic [2:0] REG_HI_B            = 3'd5;
	localparam logic [2:0] REG_NORMAL_POSITIVE = 3'd6;

	// Plane orientation codes.
	localparam logic [1:0] AXIS_XY = 2'd0;
	localparam logic [1:0] AXIS_XZ = 2'd1;
	localparam logic [1:0] AXIS_YZ = 2'd2;

	localparam int UV_BITS = 16;
	localparam int QT_BITS = 33;
	localparam int UQ_BITS = UV_BITS + 1;
	// Input transfer to result strobe, in clock edges.
	localparam int LATENCY = (QT_BITS + 1) + 4 + (UQ_BITS + 1) + 1;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic signed [31:0] tmin;
		logic signed [31:0] tmax;
	} ray_t;

	typedef struct packed {
		ray_t ray;
		logic neg;
		logic miss;
	} front_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] t;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               zero_a;
	} hitinfo_t;

endpackage

// ===== src/rair_udiv.sv =====
module rair_udiv #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int QW = 17,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic          out_ovf,
	output logic [PW-1:0] out_pay
);
	// Restoring division, one quotient bit per stage. Only the low QW quotient
	// bits are formed; a larger quotient is flagged as overflow.
	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic [NW-1:0] num_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [PW-1:0] pay_s [0:QW];
	logic [QW:0]   vld_s;
	logic [QW:0]   ovf_s;
	logic [DW-1:0] head;

	assign head = DW'(in_num[NW-1:QW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= head;
		ovf_s[0] <= head >= in_den;
		quo_s[0] <= '0;
		num_s[0] <= in_num;
		den_s[0] <= in_den;
		pay_s[0] <= in_pay;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[k], num_s[k][QW-1-k]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
			ovf_s[k+1] <= ovf_s[k];
			num_s[k+1] <= num_s[k];
			den_s[k+1] <= den_s[k];
			pay_s[k+1] <= pay_s[k];
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_ovf   = ovf_s[QW];
	assign out_pay   = pay_s[QW];
endmodule

// ===== src/rair_point.sv =====
module rair_point #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [32:0]          quo,
	input  logic                 ovf,
	input  rair_pkg::front_t     pay,
	input  logic [1:0]           plane_axis,
	input  logic signed [31:0]   lo_a,
	input  logic signed [31:0]   hi_a,
	input  logic signed [31:0]   lo_b,
	input  logic signed [31:0]   hi_b,
	output logic                 out_valid,
	output logic [31:0]          num_a,
	output logic [31:0]          num_b,
	output logic [31:0]          span_a,
	output logic [31:0]          span_b,
	output logic                 zero_b,
	output rair_pkg::hitinfo_t   info
);
	import rair_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	logic signed [33:0] tq;
	logic               t_ok;

	assign tq   = pay.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign t_ok = !pay.miss && !ovf && tq >= pay.ray.tmin && tq <= pay.ray.tmax;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic               ok_s1, ok_s2, ok_s3;
	logic signed [31:0] t_s1, t_s2, t_s3;
	ray_t               ray_s1, ray_s2;
	logic signed [63:0] prod_s2 [3];
	logic signed [63:0] pos_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Interval test, then the three products, then the floor shift and origin add.
	always_ff @(posedge clk) begin
		ok_s1  <= t_ok;
		t_s1   <= tq[31:0];
		ray_s1 <= pay.ray;

		ok_s2      <= ok_s1;
		t_s2       <= t_s1;
		ray_s2     <= ray_s1;
		prod_s2[0] <= t_s1 * ray_s1.dx;
		prod_s2[1] <= t_s1 * ray_s1.dy;
		prod_s2[2] <= t_s1 * ray_s1.dz;

		ok_s3     <= ok_s2;
		t_s3      <= t_s2;
		pos_s3[0] <= ray_s2.ox + (prod_s2[0] >>> FRAC_BITS);
		pos_s3[1] <= ray_s2.oy + (prod_s2[1] >>> FRAC_BITS);
		pos_s3[2] <= ray_s2.oz + (prod_s2[2] >>> FRAC_BITS);
	end

	logic signed [63:0] pa, pb, da, db;
	logic signed [32:0] sa, sb;
	logic               in_rect;

	always_comb begin
		case (plane_axis)
			AXIS_XY: begin
				pa = pos_s3[0];
				pb = pos_s3[1];
			end
			AXIS_XZ: begin
				pa = pos_s3[0];
				pb = pos_s3[2];
			end
			default: begin
				pa = pos_s3[1];
				pb = pos_s3[2];
			end
		endcase
	end

	assign in_rect = pa >= lo_a && pa <= hi_a && pb >= lo_b && pb <= hi_b;
	assign da      = pa - lo_a;
	assign db      = pb - lo_b;
	assign sa      = 33'(hi_a) - 33'(lo_a);
	assign sb      = 33'(hi_b) - 33'(lo_b);

	always_ff @(posedge clk) begin
		info.hit    <= ok_s3 && in_rect;
		info.t      <= t_s3;
		info.px     <= sat32(pos_s3[0]);
		info.py     <= sat32(pos_s3[1]);
		info.pz     <= sat32(pos_s3[2]);
		info.zero_a <= sa == 33'sd0;
		zero_b      <= sb == 33'sd0;
		num_a       <= da[31:0];
		num_b       <= db[31:0];
		span_a      <= sa[31:0];
		span_b      <= sb[31:0];
	end

	assign out_valid = vld_s4;
endmodule

// ===== src/ray_axis_rect_intersect.sv =====
// Channel   Direction  Handshake                Payload
// ray       in         start / busy             origin_x..z, dir_x..z, t_min, t_max
// config    in         cfg_valid / cfg_ready    cfg_index, cfg_data
// result    out        done (one-cycle strobe)  hit, t_hit, u_coord, v_coord, point_x..z
//
// One ray may be transferred in every clock cycle; busy stays low.
// Each result passes through the pipelined t divider (one quotient bit per stage),
// the interval test, products and bounds, the u/v dividers and one output register.
// The result strobe cannot be held off, so the pipeline never stalls.
// Reset clears the stage valid bits and loads the register defaults.
module ray_axis_rect_intersect #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] t_min,
	input  logic signed [31:0] t_max,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic               hit,
	output logic signed [31:0] t_hit,
	output logic [16:0]        u_coord,
	output logic [16:0]        v_coord,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);
	import rair_pkg::*;

	localparam int NUM_W = 32 + FRAC_BITS;

	// Configuration registers. Software must write them only while no ray is in flight;
	// the block does not enforce this. Every stage reads them directly.
	logic [1:0]         plane_axis_q;
	logic signed [31:0] plane_pos_q, lo_a_q, hi_a_q, lo_b_q, hi_b_q;
	logic               normal_positive_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_axis_q      <= AXIS_XY;
			plane_pos_q       <= 32'sd0;
			lo_a_q            <= 32'sd0;
			hi_a_q            <= 32'sd65536;
			lo_b_q            <= 32'sd0;
			hi_b_q            <= 32'sd65536;
			normal_positive_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PLANE_AXIS:      plane_axis_q      <= cfg_data[1:0];
				REG_PLANE_POS:       plane_pos_q       <= cfg_data;
				REG_LO_A:            lo_a_q            <= cfg_data;
				REG_HI_A:            hi_a_q            <= cfg_data;
				REG_LO_B:            lo_b_q            <= cfg_data;
				REG_HI_B:            hi_b_q            <= cfg_data;
				REG_NORMAL_POSITIVE: normal_positive_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Front end: pick the normal axis, form |plane_pos - o_n| and |d_n|, and
	// decide up front the misses that need no division.
	logic signed [31:0] on, dn;
	logic               axis_bad;
	logic signed [32:0] diff;
	logic [31:0]        diff_mag, dn_mag;
	front_t             front;

	always_comb begin
		axis_bad = 1'b0;
		case (plane_axis_q)
			AXIS_XY: begin
				on = origin_z;
				dn = dir_z;
			end
			AXIS_XZ: begin
				on = origin_y;
				dn = dir_y;
			end
			AXIS_YZ: begin
				on = origin_x;
				dn = dir_x;
			end
			default: begin
				on       = origin_x;
				dn       = dir_x;
				axis_bad = 1'b1;
			end
		endcase
	end

	assign diff     = 33'(plane_pos_q) - 33'(on);
	assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
	assign dn_mag   = dn[31] ? 32'(-33'(dn)) : dn;

	assign front.ray  = '{ox: origin_x, oy: origin_y, oz: origin_z,
			dx: dir_x, dy: dir_y, dz: dir_z, tmin: t_min, tmax: t_max};
	assign front.neg  = diff[32] ^ dn[31];
	// Parallel rays, rays from behind the one-sided normal and an invalid orientation miss.
	assign front.miss = axis_bad || dn == 32'sd0 ||
			(normal_positive_q ? !dn[31] : dn[31]);

	logic        t_vld, t_ovf;
	logic [32:0] t_quo;
	front_t      t_pay;

	rair_udiv #(
		.NW(NUM_W), .DW(32), .QW(QT_BITS), .PW($bits(front_t))
	) u_tdiv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(start && !busy),
		.in_num({diff_mag, {FRAC_BITS{1'b0}}}),
		.in_den(dn_mag),
		.in_pay(front),
		.out_valid(t_vld), .out_quo(t_quo), .out_ovf(t_ovf), .out_pay(t_pay)
	);

	logic        p_vld, p_zero_b;
	logic [31:0] p_num_a, p_num_b, p_span_a, p_span_b;
	hitinfo_t    p_info;

	rair_point #(.FRAC_BITS(FRAC_BITS)) u_point (
		.clk(clk), .arst_n(arst_n),
		.in_valid(t_vld), .quo(t_quo), .ovf(t_ovf), .pay(t_pay),
		.plane_axis(plane_axis_q),
		.lo_a(lo_a_q), .hi_a(hi_a_q), .lo_b(lo_b_q), .hi_b(hi_b_q),
		.out_valid(p_vld),
		.num_a(p_num_a), .num_b(p_num_b), .span_a(p_span_a), .span_b(p_span_b),
		.zero_b(p_zero_b), .info(p_info)
	);

	// On a hit the point lies inside the span, so the quotient is at most 1.0
	// and needs no saturation. A zero-width span is forced to 0.
	logic               u_vld, v_vld, u_ovf, v_ovf, v_zero;
	logic [UQ_BITS-1:0] u_quo, v_quo;
	hitinfo_t           u_info;

	rair_udiv #(
		.NW(32 + UV_BITS), .DW(32), .QW(UQ_BITS), .PW($bits(hitinfo_t))
	) u_udiv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(p_vld),
		.in_num({p_num_a, {UV_BITS{1'b0}}}),
		.in_den(p_span_a),
		.in_pay(p_info),
		.out_valid(u_vld), .out_quo(u_quo), .out_ovf(u_ovf), .out_pay(u_info)
	);

	rair_udiv #(
		.NW(32 + UV_BITS), .DW(32), .QW(UQ_BITS), .PW(1)
	) u_vdiv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(p_vld),
		.in_num({p_num_b, {UV_BITS{1'b0}}}),
		.in_den(p_span_b),
		.in_pay(p_zero_b),
		.out_valid(v_vld), .out_quo(v_quo), .out_ovf(v_ovf), .out_pay(v_zero)
	);

	// Output register. Every field reads zero on a miss and between strobes.
	logic               done_q, hit_q;
	logic signed [31:0] t_hit_q, point_x_q, point_y_q, point_z_q;
	logic [16:0]        u_q, v_q;
	logic               take;

	assign take = u_vld && v_vld && u_info.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			t_hit_q   <= '0;
			u_q       <= '0;
			v_q       <= '0;
			point_x_q <= '0;
			point_y_q <= '0;
			point_z_q <= '0;
		end else begin
			done_q    <= u_vld;
			hit_q     <= take;
			t_hit_q   <= take ? u_info.t : '0;
			u_q       <= (take && !u_info.zero_a && !u_ovf) ? u_quo : '0;
			v_q       <= (take && !v_zero && !v_ovf) ? v_quo : '0;
			point_x_q <= take ? u_info.px : '0;
			point_y_q <= take ? u_info.py : '0;
			point_z_q <= take ? u_info.pz : '0;
		end
	end

	assign done    = done_q;
	assign hit     = hit_q;
	assign t_hit   = t_hit_q;
	assign u_coord = u_q;
	assign v_coord = v_q;
	assign point_x = point_x_q;
	assign point_y = point_y_q;
	assign point_z = point_z_q;
endmodule

// ===== src/rair_checker.sv =====
module rair_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               hit,
	input logic signed [31:0] t_hit,
	input logic [16:0]        u_coord,
	input logic [16:0]        v_coord,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z
);
	import rair_pkg::*;

	// A result only comes out a fixed latency after a ray transfer.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
	else $error("result without a ray transfer at the pipeline latency");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !hit && t_hit == 32'sd0 && u_coord == 17'd0 && v_coord == 17'd0)
	else $error("result fields active without a strobe");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> t_hit == 32'sd0 && point_x == 32'sd0 &&
			point_y == 32'sd0 && point_z == 32'sd0 && u_coord == 17'd0 && v_coord == 17'd0)
	else $error("miss carries non-zero fields");

	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> u_coord <= 17'd65536 && v_coord <= 17'd65536)
	else $error("u or v beyond 1.0");
endmodule

bind ray_axis_rect_intersect rair_checker u_rair_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

// The driver works from a queue of rays and drives them at the falling edge. The
// monitor samples the handshakes at the rising edge. Each ray that is transferred
// is passed through the predictor straight away, and its result is queued. Each
// done strobe is then checked against the oldest queued result.
module tb;
	import rair_pkg::*;

	// One expected intersection result, at the widths of the result ports.
	typedef struct {
		logic        hit;
		logic [31:0] t;
		logic [16:0] u;
		logic [16:0] v;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} isect_t;

	// An index past the end of the register list; writes to it are ignored.
	localparam logic [2:0] REG_UNUSED_IDX = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic signed [31:0] t_min = '0, t_max = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic done, hit;
	logic signed [31:0] t_hit, point_x, point_y, point_z;
	logic [16:0] u_coord, v_coord;

	// The testbench's own copy of the rectangle settings, updated on each
	// configuration transfer.
	logic [1:0] rect_axis = AXIS_XY;
	longint rect_pos = 0, rect_lo_a = 0, rect_hi_a = 65536;
	longint rect_lo_b = 0, rect_hi_b = 65536;
	logic rect_npos = 1'b1;

	ray_t   pending_rays[$];
	isect_t expected_isects[$];
	int     burst_left = 0, gap_left = 0;
	bit     failed = 0;

	ray_axis_rect_intersect u_top (.*);

	always #1 clk = ~clk;

	// u or v within the rectangle: a zero or negative span gives 0.
	function automatic logic [16:0] rect_frac(longint p, longint lo, longint hi);
		longint span, q;
		span = hi - lo;
		if (span <= 0)
			return '0;
		q = ((p - lo) * 65536) / span;
		if (q < 0)
			q = 0;
		if (q > 65536)
			q = 65536;
		return q[16:0];
	endfunction

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic isect_t predict_isect(ray_t r);
		isect_t res;
		longint o[3], d[3], p[3];
		longint t, dn;
		int n, ia, ib;
		res = '{hit: 1'b0, t: '0, u: '0, v: '0, px: '0, py: '0, pz: '0};
		o[0] = longint'(r.ox); o[1] = longint'(r.oy); o[2] = longint'(r.oz);
		d[0] = longint'(r.dx); d[1] = longint'(r.dy); d[2] = longint'(r.dz);
		case (rect_axis)
			AXIS_XY: begin n = 2; ia = 0; ib = 1; end
			AXIS_XZ: begin n = 1; ia = 0; ib = 2; end
			AXIS_YZ: begin n = 0; ia = 1; ib = 2; end
			default: return res;
		endcase
		dn = d[n];
		// A ray parallel to the plane, or one that meets the back face, misses.
		if (dn == 0)
			return res;
		if (rect_npos ? (dn > 0) : (dn < 0))
			return res;
		t = ((rect_pos - o[n]) * 65536) / dn;
		if (t < longint'(r.tmin) || t > longint'(r.tmax))
			return res;
		for (int i = 0; i < 3; i++)
			p[i] = o[i] + ((t * d[i]) >>> 16);
		if (p[ia] < rect_lo_a || p[ia] > rect_hi_a || p[ib] < rect_lo_b || p[ib] > rect_hi_b)
			return res;
		res.hit = 1'b1;
		res.t   = clip32(t);
		res.u   = rect_frac(p[ia], rect_lo_a, rect_hi_a);
		res.v   = rect_frac(p[ib], rect_lo_b, rect_hi_b);
		res.px  = clip32(p[0]);
		res.py  = clip32(p[1]);
		res.pz  = clip32(p[2]);
		return res;
	endfunction

	// Driver: bursts of random length separated by random gaps. Now and then
	// a long stretch is run with no gaps at all.
	always @(negedge clk) begin
		if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start    <= 1'b0;
		end else if (pending_rays.size() > 0) begin
			start    <= 1'b1;
			origin_x <= pending_rays[0].ox;
			origin_y <= pending_rays[0].oy;
			origin_z <= pending_rays[0].oz;
			dir_x    <= pending_rays[0].dx;
			dir_y    <= pending_rays[0].dy;
			dir_z    <= pending_rays[0].dz;
			t_min    <= pending_rays[0].tmin;
			t_max    <= pending_rays[0].tmax;
			if (burst_left == 0) begin
				burst_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 12);
				gap_left   <= $urandom_range(0, 4);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: a ray transfer is predicted at once, and each result is checked
	// against the oldest prediction.
	always @(posedge clk) begin
		isect_t exp_r;
		if (arst_n && start && !busy && pending_rays.size() > 0) begin
			expected_isects.push_back(predict_isect(pending_rays[0]));
			void'(pending_rays.pop_front());
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PLANE_AXIS:      rect_axis = cfg_data[1:0];
				REG_PLANE_POS:       rect_pos  = longint'(signed'(cfg_data));
				REG_LO_A:            rect_lo_a = longint'(signed'(cfg_data));
				REG_HI_A:            rect_hi_a = longint'(signed'(cfg_data));
				REG_LO_B:            rect_lo_b = longint'(signed'(cfg_data));
				REG_HI_B:            rect_hi_b = longint'(signed'(cfg_data));
				REG_NORMAL_POSITIVE: rect_npos = cfg_data[0];
				default: ;
			endcase
		end
		if (arst_n && done) begin
			if (expected_isects.size() == 0) begin
				$error("result with no ray waiting for it");
				failed = 1;
			end else begin
				exp_r = expected_isects.pop_front();
				if (hit !== exp_r.hit) begin
					$error("hit: expected %0d, got %0d", exp_r.hit, hit);
					failed = 1;
				end
				if (t_hit !== exp_r.t) begin
					$error("t_hit: expected %h, got %h", exp_r.t, t_hit);
					failed = 1;
				end
				if (u_coord !== exp_r.u) begin
					$error("u_coord: expected %h, got %h", exp_r.u, u_coord);
					failed = 1;
				end
				if (v_coord !== exp_r.v) begin
					$error("v_coord: expected %h, got %h", exp_r.v, v_coord);
					failed = 1;
				end
				if (point_x !== exp_r.px) begin
					$error("point_x: expected %h, got %h", exp_r.px, point_x);
					failed = 1;
				end
				if (point_y !== exp_r.py) begin
					$error("point_y: expected %h, got %h", exp_r.py, point_y);
					failed = 1;
				end
				if (point_z !== exp_r.pz) begin
					$error("point_z: expected %h, got %h", exp_r.pz, point_z);
					failed = 1;
				end
			end
		end
	end

	// A register may only be written once the pipeline has drained.
	task automatic wait_drained();
		wait (pending_rays.size() == 0 && expected_isects.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_rect(logic [1:0] axis, logic [31:0] pos, logic [31:0] la,
			logic [31:0] ha, logic [31:0] lb, logic [31:0] hb, logic npos);
		write_reg(REG_PLANE_AXIS, {30'd0, axis});
		write_reg(REG_PLANE_POS, pos);
		write_reg(REG_LO_A, la);
		write_reg(REG_HI_A, ha);
		write_reg(REG_LO_B, lb);
		write_reg(REG_HI_B, hb);
		write_reg(REG_NORMAL_POSITIVE, {31'd0, npos});
	endtask

	function automatic ray_t noise_ray();
		return ray_t'({$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom});
	endfunction

	// A ray aimed at a random point of the current rectangle, mostly from the front side.
	function automatic ray_t aimed_ray();
		ray_t r;
		longint o[3], d[3], tt, span_a, span_b, pa, pb;
		int n, ia, ib;
		case (rect_axis)
			AXIS_XZ: begin n = 1; ia = 0; ib = 2; end
			AXIS_YZ: begin n = 0; ia = 1; ib = 2; end
			default: begin n = 2; ia = 0; ib = 1; end
		endcase
		span_a = (rect_hi_a > rect_lo_a) ? rect_hi_a - rect_lo_a : 0;
		span_b = (rect_hi_b > rect_lo_b) ? rect_hi_b - rect_lo_b : 0;
		pa = rect_lo_a + longint'({$urandom, $urandom} % (span_a + 1));
		pb = rect_lo_b + longint'({$urandom, $urandom} % (span_b + 1));
		tt = longint'($urandom_range(1, 4 << 16));
		for (int i = 0; i < 3; i++)
			d[i] = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
		d[n] = longint'($urandom_range(1, 1 << 18));
		if (rect_npos ^ ($urandom_range(0, 9) == 0))
			d[n] = -d[n];
		if ($urandom_range(0, 19) == 0)
			d[n] = 0;
		o[n]  = rect_pos - ((tt * d[n]) >>> 16);
		o[ia] = pa - ((tt * d[ia]) >>> 16);
		o[ib] = pb - ((tt * d[ib]) >>> 16);
		r.ox = 32'(o[0]); r.oy = 32'(o[1]); r.oz = 32'(o[2]);
		r.dx = 32'(d[0]); r.dy = 32'(d[1]); r.dz = 32'(d[2]);
		case ($urandom_range(0, 5))
			0:       begin r.tmin = 32'(tt); r.tmax = 32'(tt); end
			1:       begin r.tmin = 32'(tt + 2); r.tmax = 32'sh7fff_ffff; end
			2:       begin r.tmin = 32'sh8000_0000; r.tmax = 32'(tt - 2); end
			default: begin r.tmin = 0; r.tmax = 32'sh7fff_ffff; end
		endcase
		return r;
	endfunction

	task automatic random_rays(int count);
		repeat (count)
			pending_rays.push_back(($urandom_range(0, 4) == 0) ? noise_ray() : aimed_ray());
	endtask

	initial begin
		ray_t r;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rays against the unit square in the z = 0 plane after reset.
		r = '{ox: 32'sh8000, oy: 32'sh8000, oz: 32'sh10000, dx: 0, dy: 0,
			dz: -32'sh10000, tmin: 0, tmax: 32'sh7fff_ffff};
		pending_rays.push_back(r);
		r.dz = 32'sh10000;                          // back side
		pending_rays.push_back(r);
		r.dz = 0;                                   // parallel to the plane
		pending_rays.push_back(r);
		r.dz = -32'sh10000; r.tmax = 32'sh8000;     // plane lies beyond the interval
		pending_rays.push_back(r);
		r.tmax = 32'sh10000; r.tmin = 32'sh10000;   // t exactly on both ends
		pending_rays.push_back(r);
		r.ox = 0; r.oy = 0;                         // lower corner
		pending_rays.push_back(r);
		r.ox = 32'sh10000; r.oy = 32'sh10000;       // upper corner
		pending_rays.push_back(r);
		r.ox = 32'sh10001;                          // just outside
		pending_rays.push_back(r);
		r = '{ox: 32'sh7fff_ffff, oy: 32'sh8000_0000, oz: 32'sh7fff_ffff,
			dx: 32'sh7fff_ffff, dy: 32'sh8000_0000, dz: 32'sh8000_0000,
			tmin: 32'sh8000_0000, tmax: 32'sh7fff_ffff};
		pending_rays.push_back(r);
		r.oz = 32'sh8000_0000; r.dz = 32'sh7fff_ffff;
		pending_rays.push_back(r);
		r = '{ox: 0, oy: 0, oz: 32'sh8000_0000, dx: 0, dy: 0, dz: -1,
			tmin: 32'sh8000_0000, tmax: 32'sh7fff_ffff};
		pending_rays.push_back(r);
		repeat (8)
			pending_rays.push_back(noise_ray());
		random_rays(150);
		wait_drained();

		// y-plane rectangle facing minus y.
		set_rect(AXIS_XZ, 32'sh2_0000, -32'sh3_0000, 32'sh1_8000, -32'sh1000, 32'sh5_0000, 1'b0);
		random_rays(150);
		wait_drained();

		// x-plane rectangle at a random position.
		set_rect(AXIS_YZ, $urandom_range(0, 1 << 20) - (1 << 19), -32'sh4_0000, 32'sh4_0000,
			-32'sh2_0000, 32'sh7_0000, 1'b1);
		random_rays(150);
		wait_drained();

		// The full range of the bounds and the plane at an extreme.
		set_rect(AXIS_XY, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		random_rays(150);
		wait_drained();
		set_rect(AXIS_XZ, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
		random_rays(150);
		wait_drained();

		// A zero-width span on each in-plane axis.
		set_rect(AXIS_YZ, 0, 32'sh1_0000, 32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 1'b1);
		random_rays(150);
		wait_drained();
		set_rect(AXIS_XY, -32'sh8000, 0, 32'sh2_0000, 32'sh3_0000, 32'sh3_0000, 1'b0);
		random_rays(150);
		wait_drained();

		// Inverted bounds, the unused orientation and an out-of-range index.
		set_rect(AXIS_XY, 0, 32'sh2_0000, 32'sh1_0000, 0, 32'sh1_0000, 1'b1);
		random_rays(100);
		wait_drained();
		write_reg(REG_PLANE_AXIS, 32'hffff_ffff);
		write_reg(REG_UNUSED_IDX, 32'hffff_ffff);
		random_rays(100);
		wait_drained();

		// A random small rectangle for the rest of the run.
		set_rect(AXIS_XZ, $urandom_range(0, 1 << 18), 0, $urandom_range(1, 1 << 18),
			-32'sh1_0000, $urandom_range(0, 1 << 18), 1'b1);
		random_rays(150);
		wait_drained();

		if (!failed) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
